### rtl/rbt_pkg.sv
// Shared types and constants for the relay bank with toggle timers.
// Depends on nothing; the command interface, the top level, the channel and the testbench import it.
package rbt_pkg;

  localparam int unsigned MAX_CHANNELS = 8;
  localparam int unsigned CH_W         = 3;
  localparam int unsigned CMD_W        = 3;
  localparam int unsigned SEC_W        = 16;
  localparam int unsigned REM_W        = 26;
  localparam int unsigned MS_PER_SEC   = 1000;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK         = 3'd0,
    CMD_ON           = 3'd1,
    CMD_OFF          = 3'd2,
    CMD_TOGGLE       = 3'd3,
    CMD_TIMER_TOGGLE = 3'd4,
    CMD_SET_PRESET   = 3'd5
  } cmd_e;

  // One registered command on its way through the channel cells.
  typedef struct packed {
    logic             fire;
    logic [CMD_W-1:0] cmd;
    logic [CH_W-1:0]  channel;
    logic [SEC_W-1:0] seconds;
  } rbt_step_t;

  // Next-state view of one channel, captured into the result register.
  typedef struct packed {
    logic relay;
    logic expired;
    logic running;
  } rbt_stat_t;

endpackage

### rtl/rbt_cmd_if.sv
// Command channel of the relay bank: valid/ready handshake plus the command item.
// Depends on rbt_pkg for field widths.
interface rbt_cmd_if
  import rbt_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic [CH_W-1:0]  channel;
  logic [SEC_W-1:0] seconds;

  modport source (output valid, output cmd, output channel, output seconds, input ready);
  modport sink   (input valid, input cmd, input channel, input seconds, output ready);
endinterface

### rtl/rbt_res_if.sv
// Result channel of the relay bank: valid/ready handshake plus the result item.
// Depends on nothing beyond the fixed 8-bit field widths.
interface rbt_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] relay_bits;
  logic [7:0] expired_mask;
  logic [7:0] running_mask;

  modport source (output valid, output relay_bits, output expired_mask, output running_mask,
                  input ready);
  modport sink   (input valid, input relay_bits, input expired_mask, input running_mask,
                  output ready);
endinterface

### rtl/relay_bank_with_toggle_timers_top.sv
// Relay bank with one toggle timer per channel: top level.
// An accepted item passes the input register, then the channel update into the result register,
// before its result is valid. Throughput: one item per cycle while the result side does not stall.
// Reset clears all relays, timers, presets and both pipeline valid flags.
// Depends on rbt_pkg, rbt_cmd_if, rbt_res_if and rbt_channel.
module relay_bank_with_toggle_timers_top
  import rbt_pkg::*;
#(
  parameter int unsigned CHANNELS = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  rbt_cmd_if.sink      cmd_i,
  rbt_res_if.source    res_o
);

  logic             in_valid_q;
  logic [CMD_W-1:0] cmd_q;
  logic [CH_W-1:0]  ch_q;
  logic [SEC_W-1:0] secs_q;
  logic             out_valid_q;
  logic [7:0]       relay_bits_q, expired_q, running_q;
  logic [7:0]       relay_d, expired_d, running_d;
  logic             step_fire;
  logic             in_take;
  rbt_step_t        step;

  // The registered item moves on when the result register is free or being drained.
  assign step_fire   = in_valid_q && (!out_valid_q || res_o.ready);
  assign cmd_i.ready = !in_valid_q || step_fire;
  assign in_take     = cmd_i.valid && cmd_i.ready;

  assign step = '{fire: step_fire, cmd: cmd_q, channel: ch_q, seconds: secs_q};

  for (genvar g = 0; g < MAX_CHANNELS; g++) begin : g_chan
    if (g < CHANNELS) begin : g_used
      rbt_stat_t stat;
      rbt_channel #(.IDX(g)) u_channel (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .step_i (step),
        .stat_o (stat)
      );
      assign relay_d[g]   = stat.relay;
      assign expired_d[g] = stat.expired;
      assign running_d[g] = stat.running;
    end else begin : g_unused
      assign relay_d[g]   = 1'b0;
      assign expired_d[g] = 1'b0;
      assign running_d[g] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (step_fire) begin
        in_valid_q <= 1'b0;
      end
      if (step_fire) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      cmd_q  <= cmd_i.cmd;
      ch_q   <= cmd_i.channel;
      secs_q <= cmd_i.seconds;
    end
    if (step_fire) begin
      relay_bits_q <= relay_d;
      expired_q    <= expired_d;
      running_q    <= running_d;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.relay_bits   = relay_bits_q;
  assign res_o.expired_mask = expired_q;
  assign res_o.running_mask = running_q;

endmodule

### rtl/rbt_channel.sv
// One relay channel: output bit, toggle timer countdown and preset register.
// Depends on rbt_pkg for the step and status structs and the command codes.
module rbt_channel
  import rbt_pkg::*;
#(
  parameter int unsigned IDX = 0
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  rbt_step_t step_i,
  output rbt_stat_t stat_o
);

  logic             relay_q, relay_d;
  logic             run_q, run_d;
  logic [REM_W-1:0] rem_q, rem_d;
  logic [SEC_W-1:0] preset_q, preset_d;
  logic             expired;
  logic             hit;
  logic [SEC_W-1:0] start_secs;
  logic [REM_W-1:0] start_ms;
  logic signed [SEC_W:0]   diff_secs;
  logic signed [REM_W+1:0] diff_ms;
  logic signed [REM_W+1:0] adj_ms;
  logic [REM_W-1:0]        adj_clamped;

  assign hit = (step_i.channel == CH_W'(IDX));

  // A zero seconds field keeps the stored preset when a timer is started.
  assign start_secs = (step_i.seconds != '0) ? step_i.seconds : preset_q;
  assign start_ms   = REM_W'(start_secs) * REM_W'(MS_PER_SEC);

  // Moving the preset of a running timer shifts its deadline by the difference.
  assign diff_secs = $signed({1'b0, step_i.seconds}) - $signed({1'b0, preset_q});
  assign diff_ms   = (REM_W+2)'(diff_secs) * $signed((REM_W+2)'(MS_PER_SEC));
  assign adj_ms    = $signed({2'b00, rem_q}) + diff_ms;

  always_comb begin
    if (adj_ms < 0) begin
      adj_clamped = '0;
    end else if (adj_ms[REM_W+1:REM_W] != 2'b00) begin
      adj_clamped = '1;
    end else begin
      adj_clamped = adj_ms[REM_W-1:0];
    end
  end

  always_comb begin
    relay_d  = relay_q;
    run_d    = run_q;
    rem_d    = rem_q;
    preset_d = preset_q;
    expired  = 1'b0;
    if (step_i.fire) begin
      if (step_i.cmd == CMD_TICK) begin
        if (run_q) begin
          if (rem_q[REM_W-1:1] == '0) begin
            run_d    = 1'b0;
            rem_d    = '0;
            preset_d = '0;
            relay_d  = ~relay_q;
            expired  = 1'b1;
          end else begin
            rem_d = rem_q - REM_W'(1);
          end
        end
      end else if (hit) begin
        case (step_i.cmd)
          CMD_ON:     relay_d = 1'b1;
          CMD_OFF:    relay_d = 1'b0;
          CMD_TOGGLE: relay_d = ~relay_q;
          CMD_TIMER_TOGGLE: begin
            if (run_q) begin
              run_d = 1'b0;
              rem_d = '0;
            end else begin
              preset_d = start_secs;
              rem_d    = start_ms;
              run_d    = 1'b1;
            end
            relay_d = ~relay_q;
          end
          CMD_SET_PRESET: begin
            if (run_q) begin
              rem_d = adj_clamped;
            end
            preset_d = step_i.seconds;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      relay_q  <= 1'b0;
      run_q    <= 1'b0;
      rem_q    <= '0;
      preset_q <= '0;
    end else begin
      relay_q  <= relay_d;
      run_q    <= run_d;
      rem_q    <= rem_d;
      preset_q <= preset_d;
    end
  end

  assign stat_o = '{relay: relay_d, expired: expired, running: run_d};

endmodule

### sim/relay_bank_with_toggle_timers_top_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for relay_bank_with_toggle_timers_top: directed and random
// commands under varying backpressure, checked against a built-in relay/timer predictor.
// Depends on rbt_pkg, rbt_cmd_if, rbt_res_if and the block's RTL.
module relay_bank_with_toggle_timers_top_tb;
  import rbt_pkg::*;

  localparam int unsigned NUM_CH        = 8;
  localparam int unsigned PIPE_LATENCY  = 2;
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned COUNTDOWN_LEN = 1005;

  // Codes outside the command set; the block must leave its state alone for them.
  localparam logic [CMD_W-1:0] CMD_UNDEF_LO = 3'd6;
  localparam logic [CMD_W-1:0] CMD_UNDEF_HI = 3'd7;

  typedef struct packed {
    logic [7:0] relay_bits;
    logic [7:0] expired_mask;
    logic [7:0] running_mask;
  } relay_result_t;

  class relay_bank_scoreboard;
    logic [7:0]       relay_q;
    bit               timer_on  [NUM_CH];
    logic [REM_W-1:0] remain_ms [NUM_CH];
    logic [SEC_W-1:0] preset_s  [NUM_CH];
    relay_result_t    expected_q[$];
    int unsigned      mismatches;
    int unsigned      commands_seen;
    int unsigned      results_seen;
    int unsigned      expiries;

    function new();
      relay_q = '0;
      for (int i = 0; i < NUM_CH; i++) begin
        timer_on[i]  = 1'b0;
        remain_ms[i] = '0;
        preset_s[i]  = '0;
      end
      mismatches    = 0;
      commands_seen = 0;
      results_seen  = 0;
      expiries      = 0;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // Applies one accepted command to the shadow state and queues the result it causes.
    function void note_command(logic [CMD_W-1:0] cmd, logic [CH_W-1:0] ch,
                               logic [SEC_W-1:0] secs);
      relay_result_t r;
      logic [7:0]    fired;
      logic [7:0]    busy;
      longint        adj;
      fired = '0;
      busy  = '0;
      commands_seen++;
      if (cmd == CMD_TICK) begin
        for (int i = 0; i < NUM_CH; i++) begin
          if (timer_on[i]) begin
            if (remain_ms[i] <= 1) begin
              timer_on[i]  = 1'b0;
              remain_ms[i] = '0;
              preset_s[i]  = '0;
              relay_q[i]   = ~relay_q[i];
              fired[i]     = 1'b1;
            end else begin
              remain_ms[i] = remain_ms[i] - 1'b1;
            end
          end
        end
      end else if (ch < NUM_CH) begin
        case (cmd)
          CMD_ON:     relay_q[ch] = 1'b1;
          CMD_OFF:    relay_q[ch] = 1'b0;
          CMD_TOGGLE: relay_q[ch] = ~relay_q[ch];
          CMD_TIMER_TOGGLE: begin
            if (timer_on[ch]) begin
              timer_on[ch]  = 1'b0;
              remain_ms[ch] = '0;
            end else begin
              if (secs != '0) preset_s[ch] = secs;
              remain_ms[ch] = REM_W'(preset_s[ch] * MS_PER_SEC);
              timer_on[ch]  = 1'b1;
            end
            relay_q[ch] = ~relay_q[ch];
          end
          CMD_SET_PRESET: begin
            // A running timer keeps its deadline relative to the new preset.
            if (timer_on[ch]) begin
              adj = longint'(remain_ms[ch]) + longint'(secs) * MS_PER_SEC
                    - longint'(preset_s[ch]) * MS_PER_SEC;
              if (adj < 0) adj = 0;
              if (adj > longint'({REM_W{1'b1}})) adj = longint'({REM_W{1'b1}});
              remain_ms[ch] = adj[REM_W-1:0];
            end
            preset_s[ch] = secs;
          end
          default: ;
        endcase
      end
      for (int i = 0; i < NUM_CH; i++) busy[i] = timer_on[i];
      expiries += $countones(fired);
      r.relay_bits   = relay_q;
      r.expired_mask = fired;
      r.running_mask = busy;
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [7:0] relay, logic [7:0] fired, logic [7:0] busy);
      relay_result_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected result item: relay_bits %02h expired_mask %02h running_mask %02h",
               relay, fired, busy);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      results_seen++;
      if (relay !== want.relay_bits) begin
        $error("relay_bits: expected %02h, actual %02h", want.relay_bits, relay);
        mismatches++;
      end
      if (fired !== want.expired_mask) begin
        $error("expired_mask: expected %02h, actual %02h", want.expired_mask, fired);
        mismatches++;
      end
      if (busy !== want.running_mask) begin
        $error("running_mask: expected %02h, actual %02h", want.running_mask, busy);
        mismatches++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  rbt_cmd_if cmd_bus ();
  rbt_res_if res_bus ();

  relay_bank_with_toggle_timers_top #(
    .CHANNELS (NUM_CH)
  ) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_bus),
    .res_o  (res_bus)
  );

  relay_bank_scoreboard board = new();

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned stall_cycles   = 0;
  bit          hold_off_req   = 1'b0;
  bit          took_item;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Both handshakes are sampled here, input first, so a same-edge result still finds its entry.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      took_item = 1'b0;
      if (cmd_bus.valid && cmd_bus.ready) begin
        board.note_command(cmd_bus.cmd, cmd_bus.channel, cmd_bus.seconds);
        took_item = 1'b1;
      end
      if (res_bus.valid && res_bus.ready) begin
        board.check_result(res_bus.relay_bits, res_bus.expired_mask, res_bus.running_mask);
        took_item = 1'b1;
      end
      stall_cycles = took_item ? 0 : stall_cycles + 1;
    end
  end

  initial begin
    do @(posedge clk_i); while (stall_cycles < STALL_LIMIT);
    $display("Watchdog: no item moved for %0d cycles", STALL_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    res_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        res_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        res_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic push_command(input logic [CMD_W-1:0] c, input logic [CH_W-1:0] ch,
                              input logic [SEC_W-1:0] s);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    cmd_bus.valid   <= 1'b1;
    cmd_bus.cmd     <= c;
    cmd_bus.channel <= ch;
    cmd_bus.seconds <= s;
    do @(posedge clk_i); while (!cmd_bus.ready);
  endtask

  task automatic drain_results();
    cmd_bus.valid <= 1'b0;
    do @(posedge clk_i); while (board.pending() != 0);
  endtask

  function automatic logic [SEC_W-1:0] pick_seconds();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 40)      return '0;
    else if (roll < 70) return SEC_W'($urandom_range(3, 1));
    else if (roll < 80) return '1;
    else                return SEC_W'($urandom_range(16'hFFFF));
  endfunction

  task automatic random_burst(input int unsigned count);
    int unsigned      roll;
    logic [CMD_W-1:0] c;
    for (int unsigned n = 0; n < count; n++) begin
      roll = $urandom_range(99);
      if (roll < 38)      c = CMD_TICK;
      else if (roll < 42) c = CMD_ON;
      else if (roll < 46) c = CMD_OFF;
      else if (roll < 50) c = CMD_TOGGLE;
      else if (roll < 75) c = CMD_TIMER_TOGGLE;
      else if (roll < 95) c = CMD_SET_PRESET;
      else                c = $urandom_range(1) ? CMD_UNDEF_HI : CMD_UNDEF_LO;
      push_command(c, CH_W'($urandom_range(NUM_CH - 1)), pick_seconds());
    end
  endtask

  // One-second timers on a random set of idle channels, then a long run of ticks with occasional toggles.
  task automatic countdown_run();
    drain_results();
    for (int ch = 0; ch < NUM_CH; ch++) begin
      if (!board.timer_on[ch] && $urandom_range(1))
        push_command(CMD_TIMER_TOGGLE, CH_W'(ch), 16'd1);
    end
    for (int unsigned n = 0; n < COUNTDOWN_LEN; n++) begin
      if ($urandom_range(49) == 0)
        push_command(CMD_TOGGLE, CH_W'($urandom_range(NUM_CH - 1)), pick_seconds());
      else
        push_command(CMD_TICK, CH_W'($urandom_range(NUM_CH - 1)), SEC_W'($urandom));
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    cmd_bus.valid   <= 1'b0;
    cmd_bus.cmd     <= CMD_TICK;
    cmd_bus.channel <= '0;
    cmd_bus.seconds <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, no idling on either side.
    push_command(CMD_TICK,         3'd0, 16'h0000);
    push_command(CMD_ON,           3'd0, 16'h0000);
    push_command(CMD_ON,           3'd7, 16'hFFFF);
    push_command(CMD_OFF,          3'd7, 16'h0000);
    push_command(CMD_TOGGLE,       3'd3, 16'h0000);
    push_command(CMD_TOGGLE,       3'd3, 16'h0000);
    push_command(CMD_UNDEF_LO,     3'd2, 16'h1234);
    push_command(CMD_UNDEF_HI,     3'd5, 16'hFFFF);
    // A zero preset makes the timer expire on the very first tick.
    push_command(CMD_TIMER_TOGGLE, 3'd1, 16'h0000);
    push_command(CMD_TICK,         3'd0, 16'h0000);
    // Largest preset, kept by a zero seconds field, then stopped while running.
    push_command(CMD_SET_PRESET,   3'd2, 16'hFFFF);
    push_command(CMD_TIMER_TOGGLE, 3'd2, 16'h0000);
    push_command(CMD_TICK,         3'd0, 16'h0000);
    push_command(CMD_TIMER_TOGGLE, 3'd2, 16'h0000);
    // Lowering the preset under a running timer floors it, so it expires on the next tick.
    push_command(CMD_TIMER_TOGGLE, 3'd4, 16'h0001);
    push_command(CMD_TICK,         3'd0, 16'h0000);
    push_command(CMD_SET_PRESET,   3'd4, 16'h0000);
    push_command(CMD_TICK,         3'd0, 16'h0000);
    // Raising and lowering the preset under a running timer moves its deadline.
    push_command(CMD_TIMER_TOGGLE, 3'd5, 16'h0003);
    push_command(CMD_SET_PRESET,   3'd5, 16'hFFFF);
    push_command(CMD_SET_PRESET,   3'd5, 16'h0002);
    push_command(CMD_TIMER_TOGGLE, 3'd6, 16'hAAAA);
    push_command(CMD_TIMER_TOGGLE, 3'd7, 16'h5555);
    push_command(CMD_TICK,         3'd7, 16'hFFFF);
    push_command(CMD_TIMER_TOGGLE, 3'd5, 16'h0000);
    drain_results();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
        default: begin send_idle_pct = 25; recv_stall_pct = 25; end
      endcase
      case (phase)
        0: begin
          random_burst(100);
          // The result side holds off while commands keep coming, filling the pipeline.
          hold_off_req = 1'b1;
          random_burst(60);
        end
        3: begin
          random_burst(100);
          countdown_run();
          random_burst(60);
        end
        default: random_burst(170);
      endcase
      drain_results();
    end

    repeat (PIPE_LATENCY + 4) @(posedge clk_i);
    $display("Covered %0d commands across four backpressure phases and one long countdown,",
             board.commands_seen);
    $display("checking %0d results with %0d timer expiries; %0d field errors, %0d left over.",
             board.results_seen, board.expiries, board.mismatches, board.pending());
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
